@@ rtl/core/smavg_pkg.sv @@
// ----------------------------------------------------------------------------
// smavg_pkg: shared types and constants of the sample moving average
// Window size, derived widths, the front-to-back job record and the
// back-end state encoding.
// ----------------------------------------------------------------------------
package smavg_pkg;

	// window of held samples
	localparam int WINDOW      = 8;
	localparam int READ_W      = 12;
	localparam int CNT_W       = $clog2(WINDOW + 1);
	localparam int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W       = READ_W + $clog2(WINDOW);

	// rounding divider: (2*|sum| + count) / (2*count)
	localparam int DEN_W       = CNT_W + 1;
	localparam int NUM_W       = SUM_W + 1;
	localparam int STEP_W      = $clog2(NUM_W);

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

	// a reading of all ones (-1) is the sensor's fault code
	localparam logic signed [READ_W-1:0] FAULT_READING = '1;

	// one classified item, handed from front to back
	typedef struct packed {
		logic                     accepted;
		logic signed [READ_W-1:0] sample;
		logic                     err_now;
		logic                     err_new;
		logic signed [SUM_W-1:0]  sum;
		logic [CNT_W-1:0]         count;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_HOLD
	} back_state_t;

endpackage

@@ rtl/core/smavg_in_if.sv @@
// ----------------------------------------------------------------------------
// smavg_in_if: reading channel
// Valid/ready channel carrying one thermocouple reading and its fault flag.
// ----------------------------------------------------------------------------
interface smavg_in_if;
	import smavg_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [READ_W-1:0] reading;
	logic                     sensor_fault;

	modport source (output valid, output reading, output sensor_fault, input ready);
	modport sink   (input valid, input reading, input sensor_fault, output ready);

endinterface

@@ rtl/core/smavg_out_if.sv @@
// ----------------------------------------------------------------------------
// smavg_out_if: result channel
// Valid/ready channel carrying the accepted sample, error flags and mean.
// ----------------------------------------------------------------------------
interface smavg_out_if;
	import smavg_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     sample_accepted;
	logic signed [READ_W-1:0] sample_out;
	logic                     error_now;
	logic                     error_new;
	logic                     average_valid;
	logic signed [READ_W-1:0] average;

	modport source (output valid, output sample_accepted, output sample_out,
		output error_now, output error_new, output average_valid,
		output average, input ready);
	modport sink   (input valid, input sample_accepted, input sample_out,
		input error_now, input error_new, input average_valid,
		input average, output ready);

endinterface

@@ rtl/core/smavg_front.sv @@
// ----------------------------------------------------------------------------
// smavg_front: reading intake and window bookkeeping
// Classifies each reading as good or faulty, keeps the sample ring, the
// held count and the running sum, and emits one job per reading.
// ----------------------------------------------------------------------------
module smavg_front (
	input  logic               clk,
	input  logic               arst_n,
	smavg_in_if.sink           meas,
	input  logic               q_full,
	output logic               q_push,
	output smavg_pkg::job_t    q_job
);
	import smavg_pkg::*;

	logic signed [READ_W-1:0] ring_q [WINDOW];
	logic [SLOT_W-1:0]        slot_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     in_error_q;

	logic                     bad;
	logic                     full;
	logic signed [SUM_W-1:0]  sum_d;
	logic [CNT_W-1:0]         count_d;
	logic [SLOT_W-1:0]        slot_nxt;

	assign meas.ready = !q_full;
	assign q_push     = meas.valid && !q_full;

	// classify and work out the window update
	always_comb begin
		bad      = meas.sensor_fault || (meas.reading == FAULT_READING);
		full     = (count_q == CNT_W'(WINDOW));
		slot_nxt = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
		if (bad) begin
			sum_d   = '0;
			count_d = '0;
		end else if (full) begin
			sum_d   = sum_q - SUM_W'(ring_q[slot_q]) + SUM_W'(meas.reading);
			count_d = count_q;
		end else begin
			sum_d   = sum_q + SUM_W'(meas.reading);
			count_d = count_q + 1'b1;
		end
	end

	// job record for the back end
	always_comb begin
		q_job.accepted = !bad;
		q_job.sample   = bad ? '0 : meas.reading;
		q_job.err_now  = bad;
		q_job.err_new  = bad && !in_error_q;
		q_job.sum      = sum_d;
		q_job.count    = count_d;
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q     <= '0;
			count_q    <= '0;
			sum_q      <= '0;
			in_error_q <= 1'b0;
		end else if (q_push) begin
			count_q    <= count_d;
			sum_q      <= sum_d;
			in_error_q <= bad;
			if (!bad) begin
				slot_q <= slot_nxt;
			end
		end
	end

	// sample ring, written on good readings only
	always_ff @(posedge clk) begin
		if (q_push && !bad) begin
			ring_q[slot_q] <= meas.reading;
		end
	end

	a_error_empties: assert property (@(posedge clk) disable iff (!arst_n)
		in_error_q |-> (count_q == '0) && (sum_q == '0))
		else $error("window not empty while in error");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW))
		else $error("held count exceeds window");

endmodule

@@ rtl/core/smavg_queue.sv @@
// ----------------------------------------------------------------------------
// smavg_queue: job queue
// Small FIFO decoupling the intake from the divider.
// ----------------------------------------------------------------------------
module smavg_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  smavg_pkg::job_t    push_job,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output smavg_pkg::job_t    head
);
	import smavg_pkg::*;

	job_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QFILL_W-1:0] fill_q;

	assign full  = (fill_q == QFILL_W'(QUEUE_DEPTH));
	assign empty = (fill_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty))
		else $error("queue overflow or underflow");

endmodule

@@ rtl/core/smavg_back.sv @@
// ----------------------------------------------------------------------------
// smavg_back: rounding mean and result register
// Bit-serial restoring divider computing (2*|sum| + n) / (2*n), sign
// restored, then held in the result register until transferred.
// ----------------------------------------------------------------------------
module smavg_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  smavg_pkg::job_t    q_head,
	output logic               q_pop,
	smavg_out_if.source        stats
);
	import smavg_pkg::*;

	back_state_t              state_q;
	back_state_t              state_d;
	logic [STEP_W-1:0]        step_q;
	job_t                     job_q;
	logic [NUM_W-1:0]         quo_q;
	logic [DEN_W-1:0]         rem_q;
	logic [DEN_W-1:0]         den_q;
	logic signed [READ_W-1:0] avg_q;

	logic                     load;
	logic                     last_step;
	logic                     finish;
	logic [SUM_W-1:0]         mag;
	logic [DEN_W:0]           trial;
	logic                     ge;
	logic [DEN_W-1:0]         rem_d;
	logic [NUM_W-1:0]         quo_d;
	logic [READ_W-1:0]        q_mag;
	logic signed [READ_W-1:0] avg_d;

	assign last_step = (step_q == STEP_W'(NUM_W - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (!q_empty) state_d = BK_DIV;
			BK_DIV:  if (last_step) state_d = BK_HOLD;
			BK_HOLD: if (stats.ready) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		load        = 1'b0;
		finish      = 1'b0;
		stats.valid = 1'b0;
		case (state_q)
			BK_IDLE: load = !q_empty;
			BK_DIV:  finish = last_step;
			BK_HOLD: stats.valid = 1'b1;
			default: ;
		endcase
	end
	assign q_pop = load;

	// divider step and final sign handling
	always_comb begin
		mag   = q_head.sum[SUM_W-1] ? SUM_W'(-q_head.sum) : SUM_W'(q_head.sum);
		trial = {rem_q, quo_q[NUM_W-1]};
		ge    = (trial >= {1'b0, den_q});
		rem_d = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
		quo_d = {quo_q[NUM_W-2:0], ge};
		q_mag = quo_d[READ_W-1:0];
		if (job_q.count == '0) begin
			avg_d = '0;
		end else if (job_q.sum[SUM_W-1]) begin
			avg_d = -$signed(q_mag);
		end else begin
			avg_d = $signed(q_mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				step_q <= '0;
			end else if (state_q == BK_DIV) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= q_head;
			quo_q <= {mag, 1'b0} + NUM_W'(q_head.count);
			rem_q <= '0;
			den_q <= {q_head.count, 1'b0};
		end else if (state_q == BK_DIV) begin
			quo_q <= quo_d;
			rem_q <= rem_d;
		end
		if (finish) begin
			avg_q <= avg_d;
		end
	end

	assign stats.sample_accepted = job_q.accepted;
	assign stats.sample_out      = job_q.sample;
	assign stats.error_now       = job_q.err_now;
	assign stats.error_new       = job_q.err_new;
	assign stats.average_valid   = (job_q.count != '0);
	assign stats.average         = avg_q;

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV && last_step) |=> (state_q == BK_HOLD))
		else $error("divider did not hand over its result");

	a_zero_mean: assert property (@(posedge clk) disable iff (!arst_n)
		stats.valid |-> (stats.average_valid || stats.average == '0))
		else $error("mean not zero with empty window");

endmodule

@@ rtl/core/sample_moving_average_fault_reset.sv @@
// ----------------------------------------------------------------------------
// sample_moving_average_fault_reset: moving average with fault reset
// Each reading transfer yields one result transfer. The intake takes a
// reading whenever the two-entry job queue has room. The back end takes
// one job at a time: it loads the job, runs the bit-serial rounding
// divider (one quotient bit per cycle over the 16-bit numerator) and then
// presents the result until it is taken, before it takes the next job. A
// fault or a reading of -1 empties the window; the mean covers only the
// newest good samples.
// ----------------------------------------------------------------------------
module sample_moving_average_fault_reset (
	input  logic        clk,
	input  logic        arst_n,
	smavg_in_if.sink    meas,
	smavg_out_if.source stats
);
	import smavg_pkg::*;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_empty;
	job_t q_job;
	job_t q_head;

	smavg_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.meas   (meas),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (q_job)
	);

	smavg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	smavg_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.stats   (stats)
	);

endmodule

@@ tb/sample_moving_average_fault_reset_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_moving_average_fault_reset_tb: self-checking bench of the fault-reset
// moving average
// Readings go in over the valid/ready input channel. A shadow of the window
// state predicts each result record. A receiver process compares every
// result transfer, field by field, with the oldest prediction. Directed
// tests cover field extremes, fault codes, rounding and window wrap. Random
// runs of good readings and faults follow under three idle patterns, with
// one long output stall.
// ----------------------------------------------------------------------------
module sample_moving_average_fault_reset_tb;
	import smavg_pkg::*;

	// expected content of one result transfer
	typedef struct packed {
		logic                     accepted;
		logic signed [READ_W-1:0] sample;
		logic                     err_now;
		logic                     err_new;
		logic                     avg_valid;
		logic signed [READ_W-1:0] avg;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n;

	smavg_in_if  meas_if ();
	smavg_out_if stats_if ();

	sample_moving_average_fault_reset dut (
		.clk    (clk),
		.arst_n (arst_n),
		.meas   (meas_if),
		.stats  (stats_if)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow of the window state
	logic signed [READ_W-1:0] shadow_ring [WINDOW];
	logic [SLOT_W-1:0]        shadow_slot;
	logic [CNT_W-1:0]         shadow_count;
	logic signed [SUM_W-1:0]  shadow_sum;
	logic                     shadow_err;

	stats_t stats_expected [$];

	int mismatch_count = 0;
	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	int recv_hold_left = 0;

	// update the shadow window with one accepted reading, queue its result
	task automatic track_reading(input logic signed [READ_W-1:0] r, input logic f);
		stats_t e;
		int mag;
		int cnt;
		int q;
		e = '0;
		if (f || r == FAULT_READING) begin
			e.err_new    = !shadow_err;
			shadow_err   = 1'b1;
			shadow_count = '0;
			shadow_sum   = '0;
		end else begin
			shadow_err = 1'b0;
			e.accepted = 1'b1;
			e.sample   = r;
			// full window: the oldest sample drops out
			if (shadow_count == WINDOW)
				shadow_sum = shadow_sum - shadow_ring[shadow_slot];
			else
				shadow_count = shadow_count + 1'b1;
			shadow_ring[shadow_slot] = r;
			shadow_sum  = shadow_sum + r;
			shadow_slot = (shadow_slot == WINDOW - 1) ? '0 : shadow_slot + 1'b1;
		end
		e.err_now   = shadow_err;
		e.avg_valid = (shadow_count != 0);
		// mean of magnitude, rounded half away from zero, sign restored
		if (shadow_count != 0) begin
			cnt   = int'(shadow_count);
			mag   = (shadow_sum < 0) ? -int'(shadow_sum) : int'(shadow_sum);
			q     = (2 * mag + cnt) / (2 * cnt);
			e.avg = READ_W'((shadow_sum < 0) ? -q : q);
		end
		stats_expected.push_back(e);
	endtask

	// offer one reading, hold it until the transfer, then predict
	task automatic send_reading(input logic signed [READ_W-1:0] r, input logic f);
		while ($urandom_range(99) < send_idle_pct) begin
			meas_if.valid        <= 1'b0;
			meas_if.reading      <= READ_W'($urandom);
			meas_if.sensor_fault <= 1'($urandom);
			@(posedge clk);
		end
		meas_if.valid        <= 1'b1;
		meas_if.reading      <= r;
		meas_if.sensor_fault <= f;
		do @(posedge clk); while (!meas_if.ready);
		track_reading(r, f);
	endtask

	// sender pauses until every predicted result has been seen
	task automatic drain_results();
		meas_if.valid <= 1'b0;
		while (stats_expected.size() != 0) @(posedge clk);
	endtask

	// mostly in the Celsius range, some anywhere in 12 bits, a few extremes
	function automatic logic signed [READ_W-1:0] pick_reading();
		int sel;
		sel = $urandom_range(99);
		if (sel < 60)
			return READ_W'(int'($urandom_range(2070)) - 270);
		else if (sel < 90)
			return READ_W'($urandom);
		case ($urandom_range(4))
			0: return READ_W'(-2048);
			1: return READ_W'(2047);
			2: return READ_W'(0);
			3: return READ_W'(1);
			default: return READ_W'(-2);
		endcase
	endfunction

	// result check and receiver stall
	initial begin : result_side
		stats_t got;
		stats_t want;
		stats_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && stats_if.valid && stats_if.ready) begin
				got.accepted  = stats_if.sample_accepted;
				got.sample    = stats_if.sample_out;
				got.err_now   = stats_if.error_now;
				got.err_new   = stats_if.error_new;
				got.avg_valid = stats_if.average_valid;
				got.avg       = stats_if.average;
				if (stats_expected.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%t: result transfer with nothing expected", $realtime);
				end else begin
					want = stats_expected.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"%t: mismatch exp acc=%b smp=%0d err=%b new=%b ",
								"av=%b avg=%0d | got acc=%b smp=%0d err=%b new=%b av=%b avg=%0d"},
								$realtime, want.accepted, want.sample, want.err_now,
								want.err_new, want.avg_valid, want.avg, got.accepted,
								got.sample, got.err_now, got.err_new, got.avg_valid, got.avg);
					end
				end
			end
			if (recv_hold_left > 0) begin
				recv_hold_left--;
				stats_if.ready <= 1'b0;
			end else begin
				stats_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// extremes of the reading field, zero, -270 and 1800
	task automatic test_field_extremes();
		send_reading(0, 1'b0);
		send_reading(2047, 1'b0);
		send_reading(-2048, 1'b0);
		send_reading(-270, 1'b0);
		send_reading(1800, 1'b0);
	endtask

	// -1 as fault code, repeated faults, fault flag with an ordinary reading
	task automatic test_fault_codes();
		send_reading(-1, 1'b0);
		send_reading(-1, 1'b0);
		send_reading(100, 1'b1);
		send_reading(5, 1'b0);
		send_reading(-1, 1'b1);
		send_reading(-2048, 1'b1);
	endtask

	// halves round away from zero on both signs
	task automatic test_rounding();
		send_reading(1, 1'b0);
		send_reading(2, 1'b0);
		send_reading(2047, 1'b1);
		send_reading(-2, 1'b0);
		send_reading(1, 1'b0);
	endtask

	// fill the window past its size after a fault; slot position carries on
	task automatic test_window_wrap();
		send_reading(0, 1'b1);
		repeat (WINDOW + 1) send_reading(-2048, 1'b0);
		send_reading(2047, 1'b0);
	endtask

	// random runs of good readings broken by faults and some noise
	task automatic test_random_traffic(input int items, input int s_pct, input int r_pct);
		int n;
		int run_len;
		int n_fault;
		logic signed [READ_W-1:0] level;
		logic constant_run;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		n = 0;
		while (n < items) begin
			run_len      = $urandom_range(1, 20);
			constant_run = ($urandom_range(7) == 0);
			level        = $urandom_range(1) ? READ_W'(2047) : READ_W'(-2048);
			if (constant_run) run_len = $urandom_range(8, 12);
			for (int i = 0; i < run_len; i++) begin
				if (!constant_run && $urandom_range(9) == 0)
					send_reading(READ_W'($urandom), 1'($urandom));
				else
					send_reading(constant_run ? level : pick_reading(), 1'b0);
				n++;
			end
			n_fault = ($urandom_range(99) < 80) ? $urandom_range(1, 3) : 0;
			for (int i = 0; i < n_fault; i++) begin
				if ($urandom_range(2) == 0)
					send_reading(-1, 1'b0);
				else
					send_reading(READ_W'($urandom), 1'b1);
				n++;
			end
		end
		drain_results();
	endtask

	// long output stall while the sender keeps offering
	task automatic test_output_stall();
		send_idle_pct  = 0;
		recv_hold_left = 300;
		repeat (12) send_reading(pick_reading(), 1'b0);
		send_reading(7, 1'b1);
		drain_results();
	endtask

	initial begin
		shadow_slot  = '0;
		shadow_count = '0;
		shadow_sum   = '0;
		shadow_err   = 1'b0;
		foreach (shadow_ring[i]) shadow_ring[i] = '0;

		arst_n               <= 1'b0;
		meas_if.valid        <= 1'b0;
		meas_if.reading      <= '0;
		meas_if.sensor_fault <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_idle_pct = 27;
		recv_idle_pct = 69;
		test_field_extremes();
		test_fault_codes();
		test_rounding();
		test_window_wrap();
		drain_results();

		test_random_traffic(400, 27, 69);
		test_output_stall();
		test_random_traffic(400, 69, 27);
		test_random_traffic(350, 0, 0);

		drain_results();
		repeat (40) @(posedge clk);
		if (stats_expected.size() != 0)
			$display("%0d results never arrived", stats_expected.size());
		if (mismatch_count == 0 && stats_expected.size() == 0) begin
			$display("[sample_moving_average_fault_reset] OK");
		end else begin
			$display("[sample_moving_average_fault_reset] ERROR");
		end
		$finish;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("timeout");
		$display("[sample_moving_average_fault_reset] ERROR");
		$finish;
	end

endmodule
